>>> src/mmrp_pkg.sv
// Shared definitions for the meter response parser: frame constants,
// status codes, the CRC-16 byte update and the structs passed between modules.
// No dependencies.
package mmrp_pkg;

    // Frame layout, counted in received bytes
    localparam int unsigned NUM_REGS = 10;
    localparam logic [4:0] CNT_HDR_END = 5'd3;    // first data byte
    localparam logic [4:0] CNT_CRC_LO  = 5'd23;   // first CRC byte, end of CRC span
    localparam logic [4:0] CNT_CRC_HI  = 5'd24;   // last byte of a good frame
    localparam logic [4:0] CNT_OVER    = 5'd26;   // saturation value

    localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
    localparam logic [7:0]  DATA_BYTES      = 8'd20;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [15:0] PF_MAX          = 16'd100;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_LEN   = 3'd1,
        ST_BAD_ADDR  = 3'd2,
        ST_BAD_FUNC  = 3'd3,
        ST_BAD_COUNT = 3'd4,
        ST_BAD_CRC   = 3'd5
    } status_t;

    // Everything the result stage needs when the frame-end byte moves on
    typedef struct packed {
        logic                      done;       // frame-end byte advancing
        logic                      len_ok;     // frame end falls on byte CNT_CRC_HI
        logic [7:0]                hdr_addr;
        logic [7:0]                hdr_func;
        logic [7:0]                hdr_count;
        logic [7:0]                addr_latch;
        logic [15:0]               crc_calc;
        logic [15:0]               crc_rx;
        logic [NUM_REGS-1:0][15:0] regs;
    } frame_view_t;

    // Decoded result fields
    typedef struct packed {
        status_t     status;
        logic [15:0] voltage_decivolts;
        logic [31:0] current_milliamps;
        logic [31:0] power_deciwatts;
        logic [31:0] energy_watt_hours;
        logic [15:0] frequency_decihertz;
        logic [6:0]  power_factor_percent;
    } result_t;

    // CRC-16/Modbus update for one byte, reflected, eight shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> src/mmrp_frame.sv
// Input register and frame capture: byte counter, running CRC, header and
// register stores. Depends on mmrp_pkg.
module mmrp_frame (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           rx_byte,
    input  logic                 frame_end,
    input  logic [7:0]           expected_address,
    input  logic                 out_free,      // result register can take a result
    output mmrp_pkg::frame_view_t view
);

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic [7:0] in_addr_reg;

    // Frame state
    logic [4:0]  count_reg;
    logic [15:0] crc_reg;
    logic [7:0]  hdr_reg [3];
    logic [7:0]  addr_latch_reg;
    logic [7:0]  crc_lo_reg;
    logic [mmrp_pkg::NUM_REGS-1:0][15:0] regs_reg;

    logic       advance;
    logic [4:0] data_idx;
    logic [3:0] reg_sel;
    logic       data_wr;

    // A frame-end byte waits for room in the result register; others never wait
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    assign data_idx = count_reg - mmrp_pkg::CNT_HDR_END;
    assign reg_sel  = data_idx[4:1];
    assign data_wr  = (count_reg >= mmrp_pkg::CNT_HDR_END) &&
                      (count_reg < mmrp_pkg::CNT_CRC_LO);

    // Control: input valid, byte counter, running CRC
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            count_reg    <= 5'd0;
            crc_reg      <= mmrp_pkg::CRC_INIT;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                if (in_last_reg) begin
                    count_reg <= 5'd0;
                    crc_reg   <= mmrp_pkg::CRC_INIT;
                end else begin
                    if (count_reg < mmrp_pkg::CNT_OVER) begin
                        count_reg <= count_reg + 5'd1;
                    end
                    if (count_reg < mmrp_pkg::CNT_CRC_LO) begin
                        crc_reg <= mmrp_pkg::crc_byte(crc_reg, in_byte_reg);
                    end
                end
            end
        end
    end

    // Input payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= rx_byte;
            in_last_reg <= frame_end;
            in_addr_reg <= expected_address;
        end
    end

    // Header, data registers (big-endian) and received CRC low byte
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (count_reg == 5'd0) begin
                addr_latch_reg <= in_addr_reg;
            end
            if (count_reg < mmrp_pkg::CNT_HDR_END) begin
                hdr_reg[count_reg[1:0]] <= in_byte_reg;
            end
            for (int i = 0; i < mmrp_pkg::NUM_REGS; i++) begin
                if (data_wr && reg_sel == 4'(i)) begin
                    if (!data_idx[0]) begin
                        regs_reg[i][15:8] <= in_byte_reg;
                    end else begin
                        regs_reg[i][7:0] <= in_byte_reg;
                    end
                end
            end
            if (count_reg == mmrp_pkg::CNT_CRC_LO) begin
                crc_lo_reg <= in_byte_reg;
            end
        end
    end

    // The CRC high byte is the frame-end byte itself on a good-length frame
    always_comb begin
        view.done       = advance && in_last_reg;
        view.len_ok     = (count_reg == mmrp_pkg::CNT_CRC_HI);
        view.hdr_addr   = hdr_reg[0];
        view.hdr_func   = hdr_reg[1];
        view.hdr_count  = hdr_reg[2];
        view.addr_latch = addr_latch_reg;
        view.crc_calc   = crc_reg;
        view.crc_rx     = {in_byte_reg, crc_lo_reg};
        view.regs       = regs_reg;
    end

endmodule

>>> src/mmrp_eval.sv
// Frame checks, value decode and the result register.
// Depends on mmrp_pkg.
module mmrp_eval (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mmrp_pkg::frame_view_t view,
    output logic                  out_free,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output mmrp_pkg::result_t     result
);

    logic              valid_reg;
    mmrp_pkg::result_t result_reg;
    mmrp_pkg::result_t result_next;
    logic [31:0]       cur;
    logic [31:0]       pwr;
    logic [15:0]       pf_raw;

    assign out_free = !valid_reg || m_tready;

    // Checks in priority order, then decode; values zero unless ok
    always_comb begin
        cur    = {view.regs[2], view.regs[1]};
        pwr    = {view.regs[4], view.regs[3]};
        pf_raw = view.regs[8];

        result_next = '0;
        if (!view.len_ok) begin
            result_next.status = mmrp_pkg::ST_BAD_LEN;
        end else if (view.hdr_addr != view.addr_latch) begin
            result_next.status = mmrp_pkg::ST_BAD_ADDR;
        end else if (view.hdr_func != mmrp_pkg::FUNC_READ_INPUT) begin
            result_next.status = mmrp_pkg::ST_BAD_FUNC;
        end else if (view.hdr_count != mmrp_pkg::DATA_BYTES) begin
            result_next.status = mmrp_pkg::ST_BAD_COUNT;
        end else if (view.crc_calc != view.crc_rx) begin
            result_next.status = mmrp_pkg::ST_BAD_CRC;
        end else begin
            result_next.status              = mmrp_pkg::ST_OK;
            result_next.voltage_decivolts   = view.regs[0];
            result_next.current_milliamps   = cur;
            result_next.power_deciwatts     = pwr;
            result_next.energy_watt_hours   = {view.regs[6], view.regs[5]};
            result_next.frequency_decihertz = view.regs[7];
            if (cur == 32'd0 || pwr == 32'd0) begin
                result_next.power_factor_percent = 7'd0;
            end else if (pf_raw > mmrp_pkg::PF_MAX) begin
                result_next.power_factor_percent = mmrp_pkg::PF_MAX[6:0];
            end else begin
                result_next.power_factor_percent = pf_raw[6:0];
            end
        end
    end

    // Result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (view.done) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (view.done) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign result   = result_reg;

endmodule

>>> src/modbus_meter_response_parser.sv
// Top level of the meter response parser: stream ports and tdata packing.
// Depends on mmrp_pkg, mmrp_frame and mmrp_eval.
//
// Usage:
//   The slave channel carries one byte of a read-input-registers reply per
//   transfer; s_tlast marks the last byte of the frame. The expected slave
//   address travels beside each byte and is sampled with a frame's first byte.
//   The master channel gives exactly one result per frame, on the transfer
//   of its s_tlast byte, and nothing for other bytes.
//   The frame-end byte is loaded into the input register, then its result
//   into the result register, which drives m_tvalid.
//   Throughput: one byte per cycle while no frame-end byte waits; the CRC
//   byte update is a fully unrolled eight-step shift network between the
//   input register and the CRC register.
//   Reset (aresetn low, synchronous) clears the input and result valids, the
//   byte counter and the CRC; the stored header and data bytes are left as is.
//   When the receiver stalls, data bytes keep flowing in; a frame-end byte
//   waits in the input register until the result register is free, and
//   s_tready drops only while it waits.
module modbus_meter_response_parser (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // [7:0] rx_byte, [15:8] expected_address
    input  logic         s_tlast,   // frame_end
    output logic         m_tvalid,
    input  logic         m_tready,
    // [2:0] status, [18:3] voltage_decivolts, [50:19] current_milliamps,
    // [82:51] power_deciwatts, [114:83] energy_watt_hours,
    // [130:115] frequency_decihertz, [137:131] power_factor_percent, rest zero
    output logic [143:0] m_tdata
);

    mmrp_pkg::frame_view_t view;
    mmrp_pkg::result_t     result;
    logic                  out_free;

    mmrp_frame u_frame (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .rx_byte          (s_tdata[7:0]),
        .frame_end        (s_tlast),
        .expected_address (s_tdata[15:8]),
        .out_free         (out_free),
        .view             (view)
    );

    mmrp_eval u_eval (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .view     (view),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .result   (result)
    );

    // Pack result fields, first field lowest
    assign m_tdata = {6'd0,
                      result.power_factor_percent,
                      result.frequency_decihertz,
                      result.energy_watt_hours,
                      result.power_deciwatts,
                      result.current_milliamps,
                      result.voltage_decivolts,
                      result.status};

endmodule
